### rtl/core/adc_flow_linearizer_assert.svh
// ----------------------------------------------------------------------------
// adc_flow_linearizer assertion macros
// Short forms for the concurrent checks on the linearizer ports.
// ----------------------------------------------------------------------------
`ifndef ADC_FLOW_LINEARIZER_ASSERT_SVH
`define ADC_FLOW_LINEARIZER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define AFL_ASSERT_NOW(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("adc_flow_linearizer: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define AFL_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("adc_flow_linearizer: next-cycle check failed");

`endif

### rtl/core/afl_pkg.sv
// ----------------------------------------------------------------------------
// afl_pkg
// Types, widths and the voltage-to-flow breakpoint table of the linearizer.
// ----------------------------------------------------------------------------
`default_nettype none

package afl_pkg;

  // Table size and field widths
  localparam int TABLE_POINTS = 8;
  localparam int SEGMENTS     = TABLE_POINTS - 1;
  localparam int SEG_W        = $clog2(SEGMENTS);
  localparam int CODE_W       = 16;
  localparam int FLOW_W       = 15;
  localparam int FRAC_BITS    = 20;
  localparam int SCALE_W      = 28;
  localparam int PROD_W       = CODE_W - 1 + SCALE_W;   // 15 x 28 bit product
  localparam int VOLT_W       = 23;                     // 3.20 voltage
  localparam int DEN_W        = 21;                     // widest segment span
  localparam int DFLOW_W      = 12;                     // flow step of a segment
  localparam int FBASE_W      = 14;                     // breakpoint flow
  localparam int NUM_W        = DFLOW_W + DEN_W;
  localparam int QUOT_W       = DFLOW_W;                // quotient <= flow step
  localparam int QCNT_W       = $clog2(QUOT_W);

  // round(0.000188058298072402 * 2^40)
  localparam logic [SCALE_W-1:0] VOLT_SCALE = 28'd206772285;
  localparam logic [PROD_W:0]    ROUND_HALF = (PROD_W + 1)'(1) << (FRAC_BITS - 1);

  localparam logic [FLOW_W-1:0] FLOW_ERR = 15'h7FFF;   // -1
  localparam logic [FLOW_W-1:0] FLOW_MAX = 15'd10000;

  // Breakpoint voltages, Q20
  localparam logic [VOLT_W-1:0] BP_VOLT [TABLE_POINTS] = '{
    23'd1048576, 23'd3040870, 23'd3932160, 23'd4561306,
    23'd4875878, 23'd5127537, 23'd5242880, 23'd6291456
  };

  // Per-segment values: lower voltage, span, lower flow, flow step
  localparam logic [VOLT_W-1:0] SEG_BASE_V [SEGMENTS] = '{
    23'd1048576, 23'd3040870, 23'd3932160, 23'd4561306,
    23'd4875878, 23'd5127537, 23'd5242880
  };
  localparam logic [DEN_W-1:0] SEG_DEN [SEGMENTS] = '{
    21'd1992294, 21'd891290, 21'd629146, 21'd314572,
    21'd251659, 21'd115343, 21'd1048576
  };
  localparam logic [FBASE_W-1:0] SEG_BASE_F [SEGMENTS] = '{
    14'd0, 14'd1000, 14'd2000, 14'd3000, 14'd4000, 14'd5000, 14'd6000
  };
  localparam logic [DFLOW_W-1:0] SEG_DFLOW [SEGMENTS] = '{
    12'd1000, 12'd1000, 12'd1000, 12'd1000, 12'd1000, 12'd1000, 12'd4000
  };

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCALE,
    S_SEG,
    S_FETCH,
    S_PROD,
    S_START,
    S_DIV,
    S_DONE
  } afl_state_e;

endpackage

`default_nettype wire

### rtl/core/adc_flow_linearizer.sv
// ----------------------------------------------------------------------------
// adc_flow_linearizer
// Converts a signed ADC code to a flow in sccm through an 8-point table.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: adc_code_i with in_valid_i / in_stall_o. A code transfers
//   on a rising edge with in_valid_i high and in_stall_o low.
//   Output channel: flow_rate_o and out_of_range_o with out_valid_o /
//   out_stall_i. A result transfers with out_valid_o high, out_stall_i low.
//   One code is processed at a time. An in-range code steps through scale,
//   segment, fetch, product, divider start, the 12-step restoring divider
//   and done before its result enters the output register. A negative code
//   goes from scale straight to done, a code outside the table from segment.
//   A new code is taken the cycle after the previous result enters the
//   output register, so no code is accepted while one is in progress.
//   The result register frees the core: a stalled result is held stable
//   while the next code is accepted and processed; that code then waits in
//   the last step until the register is taken.
//   Reset clears the sequencer, the divider's busy flag and the output valid; the
//   breakpoint table is constant and needs no load.
// ----------------------------------------------------------------------------
`default_nettype none

module adc_flow_linearizer (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic signed [15:0]   adc_code_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic signed [14:0]        flow_rate_o,
  output logic                      out_of_range_o
);

  localparam int TABLE_POINTS = afl_pkg::TABLE_POINTS;
  localparam int SEG_W        = afl_pkg::SEG_W;
  localparam int CODE_W       = afl_pkg::CODE_W;
  localparam int PROD_W       = afl_pkg::PROD_W;
  localparam int FRAC_BITS    = afl_pkg::FRAC_BITS;
  localparam int VOLT_W       = afl_pkg::VOLT_W;
  localparam int DEN_W        = afl_pkg::DEN_W;
  localparam int DFLOW_W      = afl_pkg::DFLOW_W;
  localparam int FBASE_W      = afl_pkg::FBASE_W;
  localparam int NUM_W        = afl_pkg::NUM_W;
  localparam int QUOT_W       = afl_pkg::QUOT_W;
  localparam int FLOW_W       = afl_pkg::FLOW_W;

  afl_pkg::afl_state_e state_q, state_d;

  logic [CODE_W-2:0]   code_q;
  logic [VOLT_W-1:0]   volt_q;
  logic [SEG_W-1:0]    seg_q;
  logic [SEG_W-1:0]    seg_d;
  logic                oor_q;
  logic [DEN_W-1:0]    dv_q;
  logic [DEN_W-1:0]    den_q;
  logic [DFLOW_W-1:0]  dflow_q;
  logic [FBASE_W-1:0]  fbase_q;
  logic [NUM_W-1:0]    num_q;

  logic                out_valid_q;
  logic [FLOW_W-1:0]   flow_q;
  logic                out_oor_q;

  logic [PROD_W-1:0]   scale_prod;
  logic [PROD_W:0]     scale_sum;
  logic                volt_low;
  logic                volt_high;
  logic                in_xfer;
  logic                out_xfer;
  logic                out_load;
  logic                div_start;
  logic                div_done;
  logic [QUOT_W-1:0]   div_quot;

  assign in_xfer  = in_valid_i && !in_stall_o;
  assign out_xfer = out_valid_q && !out_stall_i;

  // code to Q20 volts, round half up
  assign scale_prod = PROD_W'(code_q) * PROD_W'(afl_pkg::VOLT_SCALE);
  assign scale_sum  = (PROD_W + 1)'(scale_prod) + afl_pkg::ROUND_HALF;

  // range check against the end breakpoints
  assign volt_low  = volt_q < afl_pkg::BP_VOLT[0];
  assign volt_high = volt_q > afl_pkg::BP_VOLT[TABLE_POINTS-1];

  // segment index: inner breakpoints strictly below the voltage
  always_comb begin
    seg_d = '0;
    for (int j = 1; j < TABLE_POINTS - 1; j++) begin
      if (volt_q > afl_pkg::BP_VOLT[j]) begin
        seg_d = seg_d + SEG_W'(1);
      end
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      afl_pkg::S_IDLE:  if (in_xfer) state_d = afl_pkg::S_SCALE;
      afl_pkg::S_SCALE: state_d = oor_q ? afl_pkg::S_DONE : afl_pkg::S_SEG;
      afl_pkg::S_SEG: begin
        state_d = (volt_low || volt_high) ? afl_pkg::S_DONE : afl_pkg::S_FETCH;
      end
      afl_pkg::S_FETCH: state_d = afl_pkg::S_PROD;
      afl_pkg::S_PROD:  state_d = afl_pkg::S_START;
      afl_pkg::S_START: state_d = afl_pkg::S_DIV;
      afl_pkg::S_DIV:   if (div_done) state_d = afl_pkg::S_DONE;
      afl_pkg::S_DONE:  if (out_load) state_d = afl_pkg::S_IDLE;
      default:          state_d = afl_pkg::S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall_o = 1'b1;
    div_start  = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      afl_pkg::S_IDLE:  in_stall_o = 1'b0;
      afl_pkg::S_START: div_start  = 1'b1;
      afl_pkg::S_DONE:  out_load   = !out_valid_q || !out_stall_i;
      default: begin
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= afl_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // datapath registers; table reads are registered in the fetch step
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      afl_pkg::S_IDLE: begin
        if (in_xfer) begin
          code_q <= adc_code_i[CODE_W-2:0];
          oor_q  <= adc_code_i[CODE_W-1];
        end
      end
      afl_pkg::S_SCALE: volt_q <= scale_sum[FRAC_BITS +: VOLT_W];
      afl_pkg::S_SEG: begin
        seg_q <= seg_d;
        oor_q <= volt_low || volt_high;
      end
      afl_pkg::S_FETCH: begin
        dv_q    <= DEN_W'(volt_q - afl_pkg::SEG_BASE_V[seg_q]);
        den_q   <= afl_pkg::SEG_DEN[seg_q];
        dflow_q <= afl_pkg::SEG_DFLOW[seg_q];
        fbase_q <= afl_pkg::SEG_BASE_F[seg_q];
      end
      afl_pkg::S_PROD: num_q <= NUM_W'(dflow_q) * NUM_W'(dv_q);
      default: begin
      end
    endcase
  end

  // flow step times offset over span
  afl_div u_afl_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num_q),
    .den_i   (den_q),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_xfer) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_oor_q <= oor_q;
      flow_q    <= oor_q ? afl_pkg::FLOW_ERR : FLOW_W'(fbase_q) + FLOW_W'(div_quot);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign flow_rate_o    = flow_q;
  assign out_of_range_o = out_oor_q;

endmodule

`default_nettype wire

### rtl/core/afl_div.sv
// ----------------------------------------------------------------------------
// afl_div
// Restoring divider: one quotient bit per cycle, MSB first.
// ----------------------------------------------------------------------------
`default_nettype none

module afl_div (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [afl_pkg::NUM_W-1:0]   num_i,
  input  wire logic [afl_pkg::DEN_W-1:0]   den_i,
  output logic                             done_o,
  output logic [afl_pkg::QUOT_W-1:0]       quot_o
);

  localparam int NUM_W  = afl_pkg::NUM_W;
  localparam int QUOT_W = afl_pkg::QUOT_W;
  localparam int QCNT_W = afl_pkg::QCNT_W;

  logic                busy_q;
  logic [QCNT_W-1:0]   cnt_q;
  logic [NUM_W-1:0]    rem_q;
  logic [NUM_W-1:0]    dsh_q;
  logic [QUOT_W-1:0]   quot_q;
  logic                ge;

  // trial subtract of the shifted divisor
  assign ge     = (rem_q >= dsh_q);
  assign done_o = busy_q && (cnt_q == '0);
  assign quot_o = quot_q;

  // busy flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
    end else if (done_o) begin
      busy_q <= 1'b0;
    end
  end

  // remainder, divisor and quotient
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= num_i;
      dsh_q  <= NUM_W'(den_i) << (QUOT_W - 1);
      cnt_q  <= QCNT_W'(QUOT_W - 1);
      quot_q <= '0;
    end else if (busy_q) begin
      if (ge) begin
        rem_q <= rem_q - dsh_q;
      end
      dsh_q  <= dsh_q >> 1;
      quot_q <= {quot_q[QUOT_W-2:0], ge};
      cnt_q  <= cnt_q - QCNT_W'(1);
    end
  end

endmodule

`default_nettype wire

### rtl/core/afl_checker.sv
// ----------------------------------------------------------------------------
// afl_checker
// Port-level checks of the linearizer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "adc_flow_linearizer_assert.svh"

module afl_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [14:0] flow_rate_o,
  input wire logic        out_of_range_o
);

  // out-of-range results carry the error flow
  `AFL_ASSERT_NOW(a_oor_flow, clk_i, rst_ni, out_valid_o && out_of_range_o, flow_rate_o == afl_pkg::FLOW_ERR)

  // in-range results lie within the table's flow span
  `AFL_ASSERT_NOW(a_flow_span, clk_i, rst_ni, out_valid_o && !out_of_range_o, flow_rate_o <= afl_pkg::FLOW_MAX)

  // one code in flight: a transfer closes the input for the next cycle
  `AFL_ASSERT_NEXT(a_single_item, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)

  // a stalled result stays put
  `AFL_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(flow_rate_o) && $stable(out_of_range_o))

endmodule

bind adc_flow_linearizer afl_checker u_afl_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .flow_rate_o    (flow_rate_o),
  .out_of_range_o (out_of_range_o)
);

`default_nettype wire
